FILE: hw/rtl/csb_pkg.sv
// csb_pkg: shared types and constants for the counting semaphore bank.
// Holds request codes, controller states, datapath commands and status.
// No dependencies.
package csb_pkg;

   localparam int CMD_W       = 2;
   localparam int IDX_W       = 3;
   localparam int TID_IN_W    = 4;
   localparam int INIT_W      = 16;
   localparam int WOKEN_W     = 4;
   localparam int MAX_RESULTS = 16;
   localparam int DRAIN_W     = $clog2(MAX_RESULTS);

   typedef enum logic [CMD_W-1:0] {
      CMD_OPEN   = 2'd0,
      CMD_CLOSE  = 2'd1,
      CMD_WAIT   = 2'd2,
      CMD_SIGNAL = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SIG_LINK,
      ST_DRAIN,
      ST_DRAIN_LINK
   } state_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_ACCEPT,
      DP_FAULT,
      DP_OPEN,
      DP_WAIT,
      DP_SIGNAL,
      DP_SIG_LINK,
      DP_CLOSE_EMPTY,
      DP_DRAIN_START,
      DP_DRAIN_EMIT,
      DP_DRAIN_LINK
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
      logic      req_ready;
   } ctl_cmd_type;

   typedef struct packed {
      logic    req_valid;
      logic    out_free;
      logic    fault;
      cmd_type cmd;
      logic    nonempty;
      logic    head_eq_tail;
      logic    drain_last;
   } dp_sts_type;

endpackage

FILE: hw/rtl/csb_if.sv
// csb_if: valid/ready channel interfaces for request and response.
// Depends on csb_pkg for field widths.
interface csb_req_if;
   logic                          valid;
   logic                          ready;
   logic [csb_pkg::CMD_W-1:0]     cmd;
   logic [csb_pkg::IDX_W-1:0]     sem_index;
   logic [csb_pkg::TID_IN_W-1:0]  thread_id;
   logic [csb_pkg::INIT_W-1:0]    init_value;

   modport source (output valid, cmd, sem_index, thread_id, init_value, input ready);
   modport sink   (input valid, cmd, sem_index, thread_id, init_value, output ready);
endinterface

interface csb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          status;
   logic                          caller_blocked;
   logic                          woken_valid;
   logic [csb_pkg::WOKEN_W-1:0]   woken_thread;
   logic                          last;

   modport source (output valid, status, caller_blocked, woken_valid, woken_thread, last,
                   input ready);
   modport sink   (input valid, status, caller_blocked, woken_valid, woken_thread, last,
                   output ready);
endinterface

FILE: hw/rtl/csb_ram.sv
// csb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module csb_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/csb_ctrl.sv
// csb_ctrl: sequencing state machine for the semaphore bank.
// Depends on csb_pkg; drives csb_datapath through ctl_cmd_type / dp_sts_type.
module csb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  csb_pkg::dp_sts_type  dp_sts,
   output csb_pkg::ctl_cmd_type ctl_cmd
);

   csb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in           = state_ff;
      ctl_cmd.op         = csb_pkg::DP_NONE;
      ctl_cmd.rsp_load   = 1'b0;
      ctl_cmd.req_ready  = 1'b0;
      unique case (state_ff)
         csb_pkg::ST_IDLE: begin
            ctl_cmd.req_ready = 1'b1;
            if (dp_sts.req_valid) begin
               ctl_cmd.op = csb_pkg::DP_ACCEPT;
               state_in   = csb_pkg::ST_EXEC;
            end
         end
         csb_pkg::ST_EXEC: begin
            if (dp_sts.out_free) begin
               ctl_cmd.rsp_load = 1'b1;
               state_in         = csb_pkg::ST_IDLE;
               if (dp_sts.fault) begin
                  ctl_cmd.op = csb_pkg::DP_FAULT;
               end else begin
                  unique case (dp_sts.cmd)
                     csb_pkg::CMD_OPEN:   ctl_cmd.op = csb_pkg::DP_OPEN;
                     csb_pkg::CMD_WAIT:   ctl_cmd.op = csb_pkg::DP_WAIT;
                     csb_pkg::CMD_SIGNAL: begin
                        ctl_cmd.op = csb_pkg::DP_SIGNAL;
                        if (dp_sts.nonempty && !dp_sts.head_eq_tail) begin
                           state_in = csb_pkg::ST_SIG_LINK;
                        end
                     end
                     csb_pkg::CMD_CLOSE: begin
                        if (dp_sts.nonempty) begin
                           ctl_cmd.op       = csb_pkg::DP_DRAIN_START;
                           ctl_cmd.rsp_load = 1'b0;
                           state_in         = csb_pkg::ST_DRAIN;
                        end else begin
                           ctl_cmd.op = csb_pkg::DP_CLOSE_EMPTY;
                        end
                     end
                     default: ctl_cmd.op = csb_pkg::DP_FAULT;
                  endcase
               end
            end
         end
         csb_pkg::ST_SIG_LINK: begin
            ctl_cmd.op = csb_pkg::DP_SIG_LINK;
            state_in   = csb_pkg::ST_IDLE;
         end
         csb_pkg::ST_DRAIN: begin
            if (dp_sts.out_free) begin
               ctl_cmd.op       = csb_pkg::DP_DRAIN_EMIT;
               ctl_cmd.rsp_load = 1'b1;
               state_in = dp_sts.drain_last ? csb_pkg::ST_IDLE : csb_pkg::ST_DRAIN_LINK;
            end
         end
         csb_pkg::ST_DRAIN_LINK: begin
            ctl_cmd.op = csb_pkg::DP_DRAIN_LINK;
            state_in   = csb_pkg::ST_DRAIN;
         end
         default: state_in = csb_pkg::ST_IDLE;
      endcase
   end

endmodule

FILE: hw/rtl/csb_datapath.sv
// csb_datapath: slot tables, wait-queue links, request latch and response register.
// Depends on csb_pkg, csb_if and csb_ram; commanded by csb_ctrl.
module csb_datapath #(
   parameter int SEM_COUNT    = 8,
   parameter int THREAD_COUNT = 16,
   parameter int COUNT_WIDTH  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   csb_req_if.sink              req_if,
   csb_rsp_if.source            rsp_if,
   input  csb_pkg::ctl_cmd_type ctl_cmd,
   output csb_pkg::dp_sts_type  dp_sts
);

   localparam int SLOT_W  = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
   localparam int TID_W   = $clog2(THREAD_COUNT);
   localparam int WORD_W  = COUNT_WIDTH + 2 * TID_W;
   localparam int IDXI_W  = csb_pkg::IDX_W;
   localparam int TIDI_W  = csb_pkg::TID_IN_W;
   localparam int INITI_W = csb_pkg::INIT_W;
   localparam int WOUT_W  = csb_pkg::WOKEN_W;
   localparam int DCNT_W  = csb_pkg::DRAIN_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // request latch
   csb_pkg::cmd_type         cmd_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic [TID_W-1:0]         tid_ff;
   logic [COUNT_WIDTH-1:0]   init_ff;
   logic                     range_fault_ff;

   logic [SEM_COUNT-1:0]     slot_open_ff, slot_open_in;
   logic [SEM_COUNT-1:0]     queue_nonempty_ff, queue_nonempty_in;
   logic [TID_W-1:0]         head_ff, head_in;
   logic [TID_W-1:0]         tail_ff, tail_in;
   logic [DCNT_W-1:0]        drain_cnt_ff, drain_cnt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_status_ff, rsp_blocked_ff, rsp_wvalid_ff, rsp_last_ff;
   logic [WOUT_W-1:0]        rsp_wthread_ff;

   logic [TIDI_W-1:0]         tid_mod;
   logic [IDXI_W+SLOT_W-1:0]  idx_wide;
   logic [TIDI_W+TID_W-1:0]   tid_wide;
   logic [INITI_W+COUNT_WIDTH-1:0] init_wide;
   logic [TID_W+WOUT_W-1:0]   wthread_wide;
   logic [SLOT_W-1:0]         req_slot;

   logic                      accept;
   logic [WORD_W-1:0]         slot_rd_data, slot_wr_data;
   logic                      slot_wr_en;
   logic [COUNT_WIDTH-1:0]    cur_count, count_dec, count_inc;
   logic [TID_W-1:0]          cur_head, cur_tail;
   logic                      cur_open, cur_nonempty, drain_last;
   logic                      next_wr_en, next_rd_en;
   logic [TID_W-1:0]          next_rd_addr, next_rd_data;

   logic                      r_status, r_blocked, r_wvalid, r_last;
   logic [TID_W-1:0]          r_wthread;

   assign accept = (ctl_cmd.op == csb_pkg::DP_ACCEPT);

   // thread number modulo THREAD_COUNT, narrow repeated subtract
   always_comb begin
      tid_mod = req_if.thread_id;
      for (int k = 0; k < 8; k++) begin
         if (32'(tid_mod) >= THREAD_COUNT) begin
            tid_mod = tid_mod - TIDI_W'(THREAD_COUNT);
         end
      end
   end

   assign idx_wide  = {{SLOT_W{1'b0}}, req_if.sem_index};
   assign req_slot  = idx_wide[SLOT_W-1:0];
   assign tid_wide  = {{TID_W{1'b0}}, tid_mod};
   assign init_wide = {{COUNT_WIDTH{1'b0}}, req_if.init_value};

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff         <= csb_pkg::cmd_type'(req_if.cmd);
         slot_ff        <= req_slot;
         tid_ff         <= tid_wide[TID_W-1:0];
         init_ff        <= init_wide[COUNT_WIDTH-1:0];
         range_fault_ff <= (32'(req_if.sem_index) >= SEM_COUNT);
      end
   end

   csb_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SEM_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_ff),
      .wr_data (slot_wr_data),
      .rd_en   (accept),
      .rd_addr (req_slot),
      .rd_data (slot_rd_data)
   );

   csb_ram #(
      .WIDTH (TID_W),
      .DEPTH (THREAD_COUNT)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (next_wr_en),
      .wr_addr (cur_tail),
      .wr_data (tid_ff),
      .rd_en   (next_rd_en),
      .rd_addr (next_rd_addr),
      .rd_data (next_rd_data)
   );

   assign cur_count    = slot_rd_data[WORD_W-1 -: COUNT_WIDTH];
   assign cur_head     = slot_rd_data[2*TID_W-1 -: TID_W];
   assign cur_tail     = slot_rd_data[TID_W-1:0];
   assign cur_open     = slot_open_ff[slot_ff];
   assign cur_nonempty = queue_nonempty_ff[slot_ff];
   assign count_dec    = cur_count - COUNT_WIDTH'(1);
   assign count_inc    = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_WIDTH'(1);
   assign drain_last   = (head_ff == tail_ff) ||
                         (drain_cnt_ff == DCNT_W'(csb_pkg::MAX_RESULTS - 1));
   assign next_rd_addr = (ctl_cmd.op == csb_pkg::DP_DRAIN_EMIT) ? head_ff : cur_head;

   always_comb begin
      slot_wr_en        = 1'b0;
      slot_wr_data      = {cur_count, cur_head, cur_tail};
      next_wr_en        = 1'b0;
      next_rd_en        = 1'b0;
      slot_open_in      = slot_open_ff;
      queue_nonempty_in = queue_nonempty_ff;
      head_in           = head_ff;
      tail_in           = tail_ff;
      drain_cnt_in      = drain_cnt_ff;
      r_status          = 1'b0;
      r_blocked         = 1'b0;
      r_wvalid          = 1'b0;
      r_wthread         = '0;
      r_last            = 1'b1;
      unique case (ctl_cmd.op)
         csb_pkg::DP_FAULT: r_status = 1'b1;
         csb_pkg::DP_OPEN: begin
            slot_wr_en                 = 1'b1;
            slot_wr_data               = {init_ff, cur_head, cur_tail};
            slot_open_in[slot_ff]      = 1'b1;
            queue_nonempty_in[slot_ff] = 1'b0;
         end
         csb_pkg::DP_WAIT: begin
            slot_wr_en = 1'b1;
            if (cur_count != '0) begin
               slot_wr_data = {count_dec, cur_head, cur_tail};
            end else begin
               r_blocked = 1'b1;
               if (!cur_nonempty) begin
                  slot_wr_data               = {cur_count, tid_ff, tid_ff};
                  queue_nonempty_in[slot_ff] = 1'b1;
               end else begin
                  slot_wr_data = {cur_count, cur_head, tid_ff};
                  next_wr_en   = 1'b1;
               end
            end
         end
         csb_pkg::DP_SIGNAL: begin
            if (cur_nonempty) begin
               r_wvalid  = 1'b1;
               r_wthread = cur_head;
               if (cur_head == cur_tail) begin
                  queue_nonempty_in[slot_ff] = 1'b0;
               end else begin
                  next_rd_en = 1'b1;
               end
            end else begin
               slot_wr_en   = 1'b1;
               slot_wr_data = {count_inc, cur_head, cur_tail};
            end
         end
         csb_pkg::DP_SIG_LINK: begin
            slot_wr_en   = 1'b1;
            slot_wr_data = {cur_count, next_rd_data, cur_tail};
         end
         csb_pkg::DP_CLOSE_EMPTY: begin
            slot_open_in[slot_ff]      = 1'b0;
            queue_nonempty_in[slot_ff] = 1'b0;
         end
         csb_pkg::DP_DRAIN_START: begin
            head_in      = cur_head;
            tail_in      = cur_tail;
            drain_cnt_in = '0;
         end
         csb_pkg::DP_DRAIN_EMIT: begin
            r_wvalid  = 1'b1;
            r_wthread = head_ff;
            r_last    = drain_last;
            if (drain_last) begin
               slot_open_in[slot_ff]      = 1'b0;
               queue_nonempty_in[slot_ff] = 1'b0;
            end else begin
               next_rd_en   = 1'b1;
               drain_cnt_in = drain_cnt_ff + DCNT_W'(1);
            end
         end
         csb_pkg::DP_DRAIN_LINK: head_in = next_rd_data;
         csb_pkg::DP_NONE, csb_pkg::DP_ACCEPT: ;
         default: ;
      endcase
   end

   assign wthread_wide = {{WOUT_W{1'b0}}, r_wthread};

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_open_ff      <= '0;
         queue_nonempty_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         slot_open_ff      <= slot_open_in;
         queue_nonempty_ff <= queue_nonempty_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff      <= head_in;
      tail_ff      <= tail_in;
      drain_cnt_ff <= drain_cnt_in;
      if (ctl_cmd.rsp_load) begin
         rsp_status_ff  <= r_status;
         rsp_blocked_ff <= r_blocked;
         rsp_wvalid_ff  <= r_wvalid;
         rsp_wthread_ff <= wthread_wide[WOUT_W-1:0];
         rsp_last_ff    <= r_last;
      end
   end

   assign rsp_valid_in = ctl_cmd.rsp_load | (rsp_valid_ff & ~rsp_if.ready);

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_status_ff;
   assign rsp_if.caller_blocked = rsp_blocked_ff;
   assign rsp_if.woken_valid    = rsp_wvalid_ff;
   assign rsp_if.woken_thread   = rsp_wthread_ff;
   assign rsp_if.last           = rsp_last_ff;
   assign req_if.ready          = ctl_cmd.req_ready;

   assign dp_sts.req_valid    = req_if.valid;
   assign dp_sts.out_free     = ~rsp_valid_ff | rsp_if.ready;
   assign dp_sts.fault        = range_fault_ff | ((cmd_ff != csb_pkg::CMD_OPEN) & ~cur_open);
   assign dp_sts.cmd          = cmd_ff;
   assign dp_sts.nonempty     = cur_nonempty;
   assign dp_sts.head_eq_tail = (cur_head == cur_tail);
   assign dp_sts.drain_last   = drain_last;

endmodule

FILE: hw/rtl/counting_semaphore_bank_core.sv
// counting_semaphore_bank_core: bank of counting semaphores with FIFO wait queues.
// Depends on csb_pkg, csb_if, csb_ctrl, csb_datapath, csb_ram.
//
// Usage:
//   req_if (sink) carries one request: cmd (open/close/wait/signal), sem_index,
//   thread_id and init_value. rsp_if (source) returns one or more responses per
//   request; last marks the final one. Both are valid/ready channels.
//   One request is in flight at a time; req_if.ready is high only when idle.
//   Sequencing: open, wait, signal without a further waiter, close with an empty
//   queue and any error go through accept, then the slot table read-modify-write;
//   a signal that leaves waiters queued adds a step to follow the next-thread link.
//   Close with waiters goes through accept and a drain start, then one response
//   and one next-thread RAM read per released thread (no read after the final
//   one), up to 16 released threads.
//   The response register frees the pipeline: the result waits there while the
//   controller returns to idle. When rsp_if.ready is low and a response is held,
//   the block stalls before writing the next response.
//   Reset (synchronous) closes all slots and empties all queues;
//   no clearing pass is needed.
module counting_semaphore_bank_core #(
   parameter int SEM_COUNT    = 8,
   parameter int THREAD_COUNT = 16,
   parameter int COUNT_WIDTH  = 16
) (
   input logic       clock,
   input logic       reset,
   csb_req_if.sink   req_if,
   csb_rsp_if.source rsp_if
);

   csb_pkg::ctl_cmd_type ctl_cmd;
   csb_pkg::dp_sts_type  dp_sts;

   csb_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .dp_sts  (dp_sts),
      .ctl_cmd (ctl_cmd)
   );

   csb_datapath #(
      .SEM_COUNT    (SEM_COUNT),
      .THREAD_COUNT (THREAD_COUNT),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .ctl_cmd (ctl_cmd),
      .dp_sts  (dp_sts)
   );

endmodule

FILE: hw/rtl/csb_checker.sv
// csb_checker: port-level assertions for counting_semaphore_bank_core.
// Depends on csb_pkg widths; bound to the top level below.
module csb_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_status,
   input logic                         rsp_caller_blocked,
   input logic                         rsp_woken_valid,
   input logic [csb_pkg::WOKEN_W-1:0]  rsp_woken_thread,
   input logic                         rsp_last
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_woken_thread) && $stable(rsp_last) && $stable(rsp_woken_valid))
      else $error("stalled response changed");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !reset && req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another in flight");

   a_drain_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken before final response");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_last && !rsp_woken_valid && !rsp_caller_blocked &&
      (rsp_woken_thread == '0))
      else $error("error response malformed");

endmodule

bind counting_semaphore_bank_core csb_checker u_csb_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_status         (rsp_if.status),
   .rsp_caller_blocked (rsp_if.caller_blocked),
   .rsp_woken_valid    (rsp_if.woken_valid),
   .rsp_woken_thread   (rsp_if.woken_thread),
   .rsp_last           (rsp_if.last)
);

FILE: sim/tb_counting_semaphore_bank_core.sv
`timescale 1ns / 100ps
// tb_counting_semaphore_bank_core: self-checking testbench for the semaphore bank core.
// Sends open/close/wait/signal requests in bursts and checks every response against
// a behavioral model. Depends on csb_pkg, csb_if and counting_semaphore_bank_core.
module tb_counting_semaphore_bank_core;

   localparam int NUM_SLOTS   = 8;
   localparam int NUM_THREADS = 16;
   localparam int UNIT_W      = 16;
   localparam logic [UNIT_W-1:0] UNIT_MAX = '1;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned RANDOM_REQUESTS = 110;

   typedef struct packed {
      logic                        status;
      logic                        caller_blocked;
      logic                        woken_valid;
      logic [csb_pkg::WOKEN_W-1:0] woken_thread;
      logic                        last;
   } sem_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csb_req_if req_chan();
   csb_rsp_if rsp_chan();

   counting_semaphore_bank_core #(
      .SEM_COUNT    (NUM_SLOTS),
      .THREAD_COUNT (NUM_THREADS),
      .COUNT_WIDTH  (UNIT_W)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   always #5 clock = ~clock;

   // semaphore bank model
   bit              slot_live   [NUM_SLOTS];
   bit [UNIT_W-1:0] slot_units  [NUM_SLOTS];
   bit              waiters_any [NUM_SLOTS];
   bit [3:0]        waiter_head [NUM_SLOTS];
   bit [3:0]        waiter_tail [NUM_SLOTS];
   bit [3:0]        waiter_link [NUM_THREADS];

   sem_rsp_t    pending_rsp[$];
   int unsigned requests_sent   = 0;
   int unsigned results_checked = 0;
   int unsigned wakeups         = 0;
   int unsigned blocked_waits   = 0;
   int unsigned error_count     = 0;
   int unsigned burst_left      = 0;
   int unsigned cycle_count     = 0;
   logic [7:0]  stall_phase     = '0;

   function automatic void push_rsp(logic st, logic blk, logic wv, logic [3:0] wt, logic lst);
      sem_rsp_t r;
      r.status         = st;
      r.caller_blocked = blk;
      r.woken_valid    = wv;
      r.woken_thread   = wv ? wt : 4'd0;
      r.last           = lst;
      pending_rsp.push_back(r);
   endfunction

   function automatic logic [3:0] pop_waiter(int unsigned s);
      logic [3:0] t;
      t = waiter_head[s];
      if (t == waiter_tail[s]) begin
         waiters_any[s] = 1'b0;
      end else begin
         waiter_head[s] = waiter_link[t];
      end
      wakeups++;
      return t;
   endfunction

   function automatic void apply_sem_op(csb_pkg::cmd_type op, logic [2:0] s, logic [3:0] tid,
                                        logic [15:0] init);
      int unsigned n;
      logic [3:0] t;
      n = 0;
      if (op == csb_pkg::CMD_OPEN) begin
         slot_live[s]   = 1'b1;
         slot_units[s]  = init[UNIT_W-1:0];
         waiters_any[s] = 1'b0;
         push_rsp(1'b0, 1'b0, 1'b0, 4'd0, 1'b1);
      end else if (!slot_live[s]) begin
         push_rsp(1'b1, 1'b0, 1'b0, 4'd0, 1'b1);
      end else begin
         case (op)
            csb_pkg::CMD_CLOSE: begin
               while (waiters_any[s] && n < csb_pkg::MAX_RESULTS) begin
                  t = pop_waiter(s);
                  n++;
                  push_rsp(1'b0, 1'b0, 1'b1, t,
                           !waiters_any[s] || n == csb_pkg::MAX_RESULTS);
               end
               if (n == 0) push_rsp(1'b0, 1'b0, 1'b0, 4'd0, 1'b1);
               waiters_any[s] = 1'b0;
               slot_live[s]   = 1'b0;
               slot_units[s]  = '0;
            end
            csb_pkg::CMD_WAIT: begin
               if (slot_units[s] != 0) begin
                  slot_units[s]--;
                  push_rsp(1'b0, 1'b0, 1'b0, 4'd0, 1'b1);
               end else begin
                  if (!waiters_any[s]) begin
                     waiter_head[s] = tid;
                     waiters_any[s] = 1'b1;
                  end else begin
                     waiter_link[waiter_tail[s]] = tid;
                  end
                  waiter_tail[s] = tid;
                  blocked_waits++;
                  push_rsp(1'b0, 1'b1, 1'b0, 4'd0, 1'b1);
               end
            end
            default: begin
               if (waiters_any[s]) begin
                  t = pop_waiter(s);
                  push_rsp(1'b0, 1'b0, 1'b1, t, 1'b1);
               end else begin
                  if (slot_units[s] != UNIT_MAX) slot_units[s]++;
                  push_rsp(1'b0, 1'b0, 1'b0, 4'd0, 1'b1);
               end
            end
         endcase
      end
   endfunction

   task automatic send_request(csb_pkg::cmd_type op, logic [2:0] s, logic [3:0] tid,
                               logic [15:0] init);
      int unsigned gap;
      logic taken;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= op;
      req_chan.sem_index  <= s;
      req_chan.thread_id  <= tid;
      req_chan.init_value <= init;
      do begin
         @(negedge clock);
         taken = req_chan.ready;
         @(posedge clock);
      end while (taken !== 1'b1);
      burst_left--;
      requests_sent++;
      apply_sem_op(op, s, tid, init);
   endtask

   function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_response();
      sem_rsp_t want;
      results_checked++;
      if (pending_rsp.size() == 0) begin
         $display("%0t: unexpected response: expected none, actual st=%0b blk=%0b wv=%0b",
                  $time, rsp_chan.status, rsp_chan.caller_blocked, rsp_chan.woken_valid);
         $display("%0t:    wt=%0d last=%0b", $time, rsp_chan.woken_thread, rsp_chan.last);
         error_count++;
      end else begin
         want = pending_rsp.pop_front();
         check_field("status", 4'(want.status), 4'(rsp_chan.status));
         check_field("caller_blocked", 4'(want.caller_blocked), 4'(rsp_chan.caller_blocked));
         check_field("woken_valid", 4'(want.woken_valid), 4'(rsp_chan.woken_valid));
         check_field("woken_thread", want.woken_thread, rsp_chan.woken_thread);
         check_field("last", 4'(want.last), 4'(rsp_chan.last));
      end
   endfunction

   // response checker: a response held at the falling edge is taken at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) check_response();
   end

   // response back-pressure: free-flowing, random, sparse and toggling windows
   always @(posedge clock) begin
      stall_phase <= stall_phase + 8'd1;
      case (stall_phase[7:6])
         2'd0: rsp_chan.ready <= 1'b1;
         2'd1: rsp_chan.ready <= ($urandom_range(0, 2) != 0);
         2'd2: rsp_chan.ready <= (stall_phase[1:0] == 2'd3);
         default: rsp_chan.ready <= stall_phase[2] ^ stall_phase[0];
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, pending_rsp.size());
         $display("tb_counting_semaphore_bank_core NOT OK");
         $finish;
      end
   end

   function automatic logic [15:0] pick_init();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         4: return UNIT_MAX;
         5: return 16'($urandom());
         default: return 16'($urandom_range(0, 3));
      endcase
   endfunction

   task automatic test_unopened_slots();
      send_request(csb_pkg::CMD_CLOSE, 3'd0, 4'd0, 16'hFFFF);
      send_request(csb_pkg::CMD_WAIT, 3'd5, 4'd9, 16'd0);
      send_request(csb_pkg::CMD_SIGNAL, 3'd7, 4'd15, 16'h5555);
   endtask

   task automatic test_counts_and_saturation();
      send_request(csb_pkg::CMD_OPEN, 3'd1, 4'd0, UNIT_MAX);
      send_request(csb_pkg::CMD_SIGNAL, 3'd1, 4'd0, 16'd0);
      send_request(csb_pkg::CMD_WAIT, 3'd1, 4'd0, 16'd0);
      send_request(csb_pkg::CMD_OPEN, 3'd2, 4'd1, 16'd1);
      send_request(csb_pkg::CMD_WAIT, 3'd2, 4'd1, 16'hAAAA);
   endtask

   task automatic test_wait_queue();
      send_request(csb_pkg::CMD_OPEN, 3'd4, 4'd0, 16'd0);
      send_request(csb_pkg::CMD_WAIT, 3'd4, 4'd15, 16'd0);
      send_request(csb_pkg::CMD_WAIT, 3'd4, 4'd0, 16'd0);
      send_request(csb_pkg::CMD_WAIT, 3'd4, 4'd15, 16'd0);
      repeat (3) send_request(csb_pkg::CMD_SIGNAL, 3'd4, 4'd3, 16'd0);
      send_request(csb_pkg::CMD_SIGNAL, 3'd4, 4'd3, 16'd0);
      send_request(csb_pkg::CMD_WAIT, 3'd4, 4'd8, 16'd0);
   endtask

   task automatic test_reopen();
      send_request(csb_pkg::CMD_WAIT, 3'd4, 4'd7, 16'd0);
      send_request(csb_pkg::CMD_OPEN, 3'd4, 4'd7, 16'd0);
      send_request(csb_pkg::CMD_SIGNAL, 3'd4, 4'd7, 16'd0);
   endtask

   task automatic test_close();
      send_request(csb_pkg::CMD_WAIT, 3'd4, 4'd2, 16'd0);
      send_request(csb_pkg::CMD_WAIT, 3'd4, 4'd3, 16'd0);
      send_request(csb_pkg::CMD_WAIT, 3'd4, 4'd6, 16'd0);
      send_request(csb_pkg::CMD_CLOSE, 3'd4, 4'd0, 16'd0);
      send_request(csb_pkg::CMD_CLOSE, 3'd4, 4'd0, 16'd0);
      send_request(csb_pkg::CMD_CLOSE, 3'd2, 4'd0, 16'd0);
   endtask

   // more waiters than one close can release
   task automatic test_long_drain();
      send_request(csb_pkg::CMD_OPEN, 3'd6, 4'd0, 16'd0);
      repeat (csb_pkg::MAX_RESULTS + 2) begin
         send_request(csb_pkg::CMD_WAIT, 3'd6, 4'($urandom_range(0, 15)), 16'd0);
      end
      send_request(csb_pkg::CMD_CLOSE, 3'd6, 4'd0, 16'd0);
      send_request(csb_pkg::CMD_SIGNAL, 3'd6, 4'd1, 16'd0);
   endtask

   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned len;
      logic [2:0] s;
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         if ($urandom_range(0, 3) == 0) begin
            send_request(csb_pkg::cmd_type'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                         4'($urandom_range(0, 15)), 16'($urandom()));
            sent++;
         end else begin
            s = 3'($urandom_range(0, 7));
            if (!slot_live[s]) begin
               send_request(csb_pkg::CMD_OPEN, s, 4'($urandom_range(0, 15)), pick_init());
               sent++;
            end
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 20) : $urandom_range(2, 10);
            repeat (len) begin
               if ($urandom_range(0, 9) < 6) begin
                  send_request(csb_pkg::CMD_WAIT, s, 4'($urandom_range(0, 15)),
                               16'($urandom()));
               end else begin
                  send_request(csb_pkg::CMD_SIGNAL, s, 4'($urandom_range(0, 15)),
                               16'($urandom()));
               end
               sent++;
            end
            if ($urandom_range(0, 2) == 0) begin
               send_request(csb_pkg::CMD_CLOSE, s, 4'($urandom_range(0, 15)), 16'($urandom()));
               sent++;
            end
         end
      end
   endtask

   initial begin
      req_chan.valid      <= 1'b0;
      req_chan.cmd        <= csb_pkg::CMD_OPEN;
      req_chan.sem_index  <= '0;
      req_chan.thread_id  <= '0;
      req_chan.init_value <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_unopened_slots();
      test_counts_and_saturation();
      test_wait_queue();
      test_reopen();
      test_close();
      test_long_drain();
      test_random_traffic();

      req_chan.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses, %0d errors.",
               requests_sent, results_checked, error_count);
      $display("Model saw %0d blocked waits and %0d released threads.", blocked_waits, wakeups);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("tb_counting_semaphore_bank_core OK");
      end else begin
         $display("tb_counting_semaphore_bank_core NOT OK");
      end
      $finish;
   end

endmodule
